@@ hw/rtl/bfpf_pkg.sv @@
package bfpf_pkg;

   localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND     = 8'h62;
   localparam logic [15:0] MAX_LEN_RESET   = 16'd256;
   localparam int          CSR_ADDR_W      = 3;
   localparam int          CSR_DATA_W      = 32;
   localparam logic [0:0]  REG_MAX_PAYLOAD = 1'b0;

   typedef enum logic [3:0] {
      PH_SYNC1  = 4'd0,
      PH_SYNC2  = 4'd1,
      PH_CLASS  = 4'd2,
      PH_ID     = 4'd3,
      PH_LEN_LO = 4'd4,
      PH_LEN_HI = 4'd5,
      PH_PAYLD  = 4'd6,
      PH_CK_A   = 4'd7,
      PH_CK_B   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2
   } kind_type;

endpackage

@@ hw/rtl/binary_frame_parser_fletcher_top.sv @@
// Channel   Direction  Ports                                    Handshake
// req       in         req_rx_byte                              req_valid / req_stall
// rsp       out        rsp_kind, rsp_data_byte, rsp_byte_index, rsp_valid / rsp_stall
//                      rsp_msg_class, rsp_msg_id, rsp_payload_length
// csr       in/out     csr_psel .. csr_prdata, csr_pready       APB write, pready high
//
// One byte per cycle while the request side is not stalled. A byte is parsed in the cycle it
// is accepted; its result is registered into the output register at the end of that cycle.
// The output register decouples the sides: bytes flow whenever it is empty or being taken.
// A result waiting under rsp_stall stalls the request side until it is taken.
// Synchronous active-high reset returns to sync hunt, max length 256.
module binary_frame_parser_fletcher_top
   import bfpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [15:0]           rsp_byte_index,
   output logic [7:0]            rsp_msg_class,
   output logic [7:0]            rsp_msg_id,
   output logic [15:0]           rsp_payload_length,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] max_len_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  oclass_ff;
   logic [7:0]  oid_ff;
   logic [15:0] olength_ff;

   logic        accept;
   logic        emit;
   logic [7:0]  b;
   logic [15:0] len_full;
   logic [7:0]  acc_a;
   logic [7:0]  acc_b;
   logic [16:0] count_next;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_PAYLOAD) ?
                       {{(CSR_DATA_W-16){1'b0}}, max_len_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write && csr_paddr[2] == REG_MAX_PAYLOAD) begin
         max_len_ff <= csr_pwdata[15:0];
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign b         = req_rx_byte;
   assign len_full  = {b, length_ff[7:0]};
   assign acc_a     = sum_a_ff + b;
   assign acc_b     = sum_b_ff + acc_a;
   assign count_next = {1'b0, count_ff} + 17'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2:  phase_in = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            PH_CLASS:  phase_in = PH_ID;
            PH_ID:     phase_in = PH_LEN_LO;
            PH_LEN_LO: phase_in = PH_LEN_HI;
            PH_LEN_HI: begin
               if (len_full > max_len_ff) begin
                  phase_in = PH_SYNC1;
               end else if (len_full != 16'd0) begin
                  phase_in = PH_PAYLD;
               end else begin
                  phase_in = PH_CK_A;
               end
            end
            PH_PAYLD:  phase_in = (count_next >= {1'b0, length_ff}) ? PH_CK_A : PH_PAYLD;
            PH_CK_A:   phase_in = (b == sum_a_ff) ? PH_CK_B : PH_SYNC1;
            PH_CK_B:   phase_in = PH_SYNC1;
            default:   phase_in = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
         endcase
      end
   end

   // frame fields, sums and result
   always_comb begin
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      kind_in   = KIND_PAYLOAD;
      data_in   = 8'd0;
      index_in  = 16'd0;
      if (accept) begin
         unique case (phase_ff)
            PH_CLASS: begin
               class_in = b;
               sum_a_in = b;
               sum_b_in = b;
            end
            PH_ID: begin
               id_in    = b;
               sum_a_in = acc_a;
               sum_b_in = acc_b;
            end
            PH_LEN_LO: begin
               length_in = {8'd0, b};
               sum_a_in  = acc_a;
               sum_b_in  = acc_b;
            end
            PH_LEN_HI: begin
               length_in = len_full;
               // oversize frames keep the sums untouched
               if (len_full <= max_len_ff) begin
                  sum_a_in = acc_a;
                  sum_b_in = acc_b;
                  count_in = 16'd0;
               end
            end
            PH_PAYLD: begin
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               count_in = count_next[15:0];
               emit     = 1'b1;
               kind_in  = KIND_PAYLOAD;
               data_in  = b;
               index_in = count_ff;
            end
            PH_CK_A: begin
               if (b != sum_a_ff) begin
                  emit    = 1'b1;
                  kind_in = KIND_BAD;
               end
            end
            PH_CK_B: begin
               emit    = 1'b1;
               kind_in = (b == sum_b_ff) ? KIND_GOOD : KIND_BAD;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         class_ff     <= 8'd0;
         id_ff        <= 8'd0;
         length_ff    <= 16'd0;
         count_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         class_ff     <= class_in;
         id_ff        <= id_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word reports frame fields as they stood before this byte
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff    <= kind_in;
         data_ff    <= data_in;
         index_ff   <= index_in;
         oclass_ff  <= class_ff;
         oid_ff     <= id_ff;
         olength_ff <= length_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_byte_index     = index_ff;
   assign rsp_msg_class      = oclass_ff;
   assign rsp_msg_id         = oid_ff;
   assign rsp_payload_length = olength_ff;

   a_stall_only_on_held_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with no word held");

   a_frame_word_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != KIND_PAYLOAD) |-> (data_ff == 8'd0 && index_ff == 16'd0))
      else $error("frame status word carries payload fields");

   a_index_below_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_PAYLOAD) |-> (index_ff < olength_ff))
      else $error("payload index beyond declared length");

   a_ck_b_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_CK_B) |=> (phase_ff == PH_SYNC1 && rsp_valid_ff))
      else $error("second checksum byte did not close the frame");

endmodule

@@ tb/sv/binary_frame_parser_fletcher_top_test.sv @@
module binary_frame_parser_fletcher_top_test;
   import bfpf_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] MAX_LEN_ADDR = CSR_ADDR_W'(4 * int'(REG_MAX_PAYLOAD));
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR  = MAX_LEN_ADDR + CSR_ADDR_W'(4);
   localparam int CYCLE_LIMIT = 400000;

   typedef enum {FR_GOOD, FR_BAD_A, FR_BAD_B, FR_OVERSIZE, FR_BAD_SYNC, FR_TRUNC} frame_shape_type;

   typedef struct packed {
      logic [7:0] value;
      bit         drain;   // hold this word back until all results are in
   } rx_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] index;
      logic [7:0]  cls;
      logic [7:0]  id;
      logic [15:0] len;
   } parse_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_rx_byte = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_data_byte;
   logic [15:0]           rsp_byte_index;
   logic [7:0]            rsp_msg_class;
   logic [7:0]            rsp_msg_id;
   logic [15:0]           rsp_payload_length;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   binary_frame_parser_fletcher_top dut (.*);

   always #4 clock = ~clock;

   rx_item_type      pending_bytes[$];
   parse_result_type expected_results[$];
   bit               failed = 1'b0;
   int               gap_pct = 28;
   int               cycle_count = 0;

   // parser mirror
   phase_type   parse_ph = PH_SYNC1;
   logic [7:0]  run_a = 8'd0;
   logic [7:0]  run_b = 8'd0;
   logic [7:0]  cur_class = 8'd0;
   logic [7:0]  cur_id = 8'd0;
   logic [15:0] cur_len = 16'd0;
   logic [15:0] pay_count = 16'd0;
   logic [15:0] len_limit = MAX_LEN_RESET;

   function automatic bit parse_byte(input logic [7:0] b, output parse_result_type res);
      bit emits;
      emits = 1'b0;
      res.kind = KIND_PAYLOAD;
      res.data = 8'd0;
      res.index = 16'd0;
      case (parse_ph)
         PH_SYNC2: parse_ph = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
         PH_CLASS: begin
            cur_class = b;
            run_a = b;
            run_b = b;
            parse_ph = PH_ID;
         end
         PH_ID: begin
            cur_id = b;
            run_a = run_a + b;
            run_b = run_b + run_a;
            parse_ph = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            cur_len = {8'd0, b};
            run_a = run_a + b;
            run_b = run_b + run_a;
            parse_ph = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            cur_len = {b, cur_len[7:0]};
            if (cur_len > len_limit) begin
               parse_ph = PH_SYNC1;
            end else begin
               run_a = run_a + b;
               run_b = run_b + run_a;
               pay_count = 16'd0;
               parse_ph = (cur_len != 16'd0) ? PH_PAYLD : PH_CK_A;
            end
         end
         PH_PAYLD: begin
            run_a = run_a + b;
            run_b = run_b + run_a;
            res.data = b;
            res.index = pay_count;
            if (17'(pay_count) + 17'd1 >= 17'(cur_len)) parse_ph = PH_CK_A;
            pay_count = pay_count + 16'd1;
            emits = 1'b1;
         end
         PH_CK_A: begin
            if (b == run_a) begin
               parse_ph = PH_CK_B;
            end else begin
               parse_ph = PH_SYNC1;
               res.kind = KIND_BAD;
               emits = 1'b1;
            end
         end
         PH_CK_B: begin
            parse_ph = PH_SYNC1;
            res.kind = (b == run_b) ? KIND_GOOD : KIND_BAD;
            emits = 1'b1;
         end
         default: parse_ph = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
      endcase
      res.cls = cur_class;
      res.id = cur_id;
      res.len = cur_len;
      return emits;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   // Builds one frame on the wire; returns the number of words queued.
   function automatic int add_frame(input frame_shape_type shape, input logic [7:0] cls,
                                    input logic [7:0] id, input logic [15:0] len,
                                    input bit drain);
      logic [7:0] wire_bytes[$];
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      int keep;
      wire_bytes = {SYNC_FIRST, SYNC_SECOND, cls, id, len[7:0], len[15:8]};
      if (shape == FR_BAD_SYNC)
         wire_bytes[1] = $urandom_range(1) ? SYNC_FIRST : SYNC_SECOND ^ 8'($urandom_range(255, 1));
      if (shape != FR_OVERSIZE) begin
         repeat (len) wire_bytes.insert(wire_bytes.size(), 8'($urandom_range(255)));
         ck_a = 8'd0;
         ck_b = 8'd0;
         for (int i = 2; i < wire_bytes.size(); i++) begin
            ck_a = ck_a + wire_bytes[i];
            ck_b = ck_b + ck_a;
         end
         if (shape == FR_BAD_A) ck_a = ck_a ^ 8'($urandom_range(255, 1));
         if (shape == FR_BAD_B) ck_b = ck_b ^ 8'($urandom_range(255, 1));
         wire_bytes.insert(wire_bytes.size(), ck_a);
         wire_bytes.insert(wire_bytes.size(), ck_b);
      end
      if (shape == FR_TRUNC) begin
         keep = $urandom_range(wire_bytes.size() - 1, 3);
         while (wire_bytes.size() > keep) void'(wire_bytes.pop_back());
      end
      foreach (wire_bytes[i])
         pending_bytes.insert(pending_bytes.size(),
                              '{value: wire_bytes[i], drain: drain && i == 0});
      return wire_bytes.size();
   endfunction

   function automatic void add_random_traffic(input int budget);
      int made;
      int pick;
      int cap;
      logic [15:0] len;
      frame_shape_type shape;
      made = 0;
      while (made < budget) begin
         pick = $urandom_range(99);
         cap = (len_limit > 12) ? 12 : len_limit;
         if ($urandom_range(9) == 0) cap = (len_limit > 40) ? 40 : len_limit;
         len = 16'($urandom_range(cap, 0));
         if (pick < 70) shape = FR_GOOD;
         else if (pick < 78) shape = FR_BAD_A;
         else if (pick < 85) shape = FR_BAD_B;
         else if (pick < 90) shape = FR_OVERSIZE;
         else if (pick < 94) shape = FR_BAD_SYNC;
         else shape = FR_TRUNC;
         if (shape == FR_OVERSIZE) begin
            if (len_limit == 16'hFFFF) shape = FR_GOOD;
            else if ($urandom_range(1)) len = len_limit + 16'd1;
            else len = 16'($urandom_range(65535, int'(len_limit) + 1));
         end
         if (pick >= 97) begin
            // line noise, heavy on first sync words
            repeat ($urandom_range(6, 1)) begin
               pending_bytes.insert(pending_bytes.size(),
                                    '{value: ($urandom_range(9) < 3) ? SYNC_FIRST
                                             : 8'($urandom_range(255)), drain: 1'b0});
               made++;
            end
         end else begin
            made += add_frame(shape, 8'($urandom_range(255)), 8'($urandom_range(255)), len,
                              $urandom_range(29) == 0);
         end
      end
   endfunction

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == MAX_LEN_ADDR) len_limit = value[15:0];
   endtask

   // byte driver and parser tracking
   always @(posedge clock) begin : drive_words
      parse_result_type res;
      rx_item_type nxt;
      bit accepted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted && parse_byte(req_rx_byte, res))
            expected_results.insert(expected_results.size(), res);
         if (req_valid && !accepted) begin
            // stalled: hold word
         end else if (pending_bytes.size() != 0
                      && !(pending_bytes[0].drain && expected_results.size() != 0)
                      && $urandom_range(99) >= gap_pct) begin
            nxt = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_rx_byte <= nxt.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_words
      parse_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got kind %0d index %0h",
                        $time, rsp_kind, rsp_byte_index);
               failed = 1'b1;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("data_byte", 16'(want.data), 16'(rsp_data_byte));
               check_field("byte_index", want.index, rsp_byte_index);
               check_field("msg_class", 16'(want.cls), 16'(rsp_msg_class));
               check_field("msg_id", 16'(want.id), 16'(rsp_msg_id));
               check_field("payload_length", want.len, rsp_payload_length);
            end
         end
         rsp_stall <= ($urandom_range(99) < gap_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d words still expected", $time, expected_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero length, bad checksum A, repeated first sync, oversize just above reset limit
      void'(add_frame(FR_GOOD, 8'hFF, 8'h00, 16'd0, 1'b0));
      void'(add_frame(FR_BAD_A, 8'h00, 8'hFF, 16'd1, 1'b0));
      pending_bytes.insert(pending_bytes.size(), '{value: SYNC_FIRST, drain: 1'b0});
      pending_bytes.insert(pending_bytes.size(), '{value: SYNC_FIRST, drain: 1'b0});
      pending_bytes.insert(pending_bytes.size(), '{value: SYNC_SECOND, drain: 1'b0});
      void'(add_frame(FR_OVERSIZE, 8'h5A, 8'hA5, MAX_LEN_RESET + 16'd1, 1'b0));
      add_random_traffic(270);
      wait_idle();

      // upper data bits are don't-care
      csr_write(MAX_LEN_ADDR, {16'($urandom), 16'd0});
      add_random_traffic(270);
      wait_idle();

      gap_pct = 0;
      csr_write(MAX_LEN_ADDR, 32'h0000_FFFF);
      void'(add_frame(FR_GOOD, 8'h01, 8'h07, 16'd300, 1'b0));
      add_random_traffic(270);
      wait_idle();
      gap_pct = 28;

      csr_write(MAX_LEN_ADDR, 32'd3);
      add_random_traffic(270);
      wait_idle();

      csr_write(UNUSED_ADDR, $urandom);
      csr_write(MAX_LEN_ADDR, 32'($urandom_range(60, 1)));
      add_random_traffic(270);
      wait_idle();
      repeat (8) @(posedge clock);

      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived, expected kind %0d", $time,
                  expected_results.size(), expected_results[0].kind);
         failed = 1'b1;
      end
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
